// ===== sv/pdx_pkg.sv =====
package pdx_pkg;

	localparam logic [1:0] STATUS_NONE    = 2'd0;
	localparam logic [1:0] STATUS_MORE    = 2'd1;
	localparam logic [1:0] STATUS_PARTIAL = 2'd2;
	localparam logic [1:0] STATUS_MATCHED = 2'd3;

	localparam logic [15:0] WINDOW_RESET = 16'd4096;

	localparam int HIST_BYTES = 9;
	localparam int HEAD_LEN   = 5;

	localparam logic [71:0] STARTXREF_PAT = "startxref";
	localparam logic [55:0] TRAILER_PAT   = "trailer";
	localparam logic [39:0] EOF_PAT       = "%%EOF";

	typedef logic [8*HIST_BYTES-1:0] hist_t;

	function automatic logic [7:0] head_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = "%";
			3'd1: b = "P";
			3'd2: b = "D";
			3'd3: b = "F";
			3'd4: b = "-";
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic is_c_space(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

endpackage

// ===== sv/pdx_byte_if.sv =====
interface pdx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       final_chunk;

	modport source(output valid, output data_byte, output last_byte, output final_chunk,
		input ready);
	modport sink(input valid, input data_byte, input last_byte, input final_chunk,
		output ready);
endinterface

// ===== sv/pdx_result_if.sv =====
interface pdx_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] extent_length;

	modport source(output valid, output status, output extent_length, input ready);
	modport sink(input valid, input status, input extent_length, output ready);
endinterface

// ===== sv/pdf_extent_detector.sv =====
// An accepted byte is registered in the input stage; a last byte then loads the
// result register, which offers its result on result_ch until it is taken.
// Throughput: one byte per cycle. A last byte holds in the input stage while an
// earlier result is still unread, which stops byte intake until it is taken.
// Reset (arst_n low): scan state cleared, window back to 4096, no result
// pending.
module pdf_extent_detector #(
	parameter int OFFSET_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	pdx_byte_if.sink           byte_ch,
	pdx_result_if.source       result_ch
);

	localparam int OB = OFFSET_BITS;

	// input stage
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        final_s1;

	// scan state
	logic [15:0]           window_q;
	pdx_pkg::hist_t        hist_q;
	logic [OB-1:0]         offset_q;
	logic                  header_ok_q;
	logic                  sx_valid_q;
	logic [OB-1:0]         sx_at_q;
	logic                  tr_valid_q;
	logic [OB-1:0]         tr_at_q;
	logic                  found_q;
	logic [OB:0]           match_end_q;
	logic                  extending_q;

	// result register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] extent_q;

	logic advance_s1;

	assign advance_s1   = valid_s1 && (!last_s1 || !out_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			data_s1  <= byte_ch.data_byte;
			last_s1  <= byte_ch.last_byte;
			final_s1 <= byte_ch.final_chunk;
		end
	end

	// next-state logic
	pdx_pkg::hist_t hist_n;
	logic [OB-1:0]  offset_n;
	logic           header_ok_n;
	logic           sx_valid_n;
	logic [OB-1:0]  sx_at_n;
	logic           tr_valid_n;
	logic [OB-1:0]  tr_at_n;
	logic           found_n;
	logic [OB:0]    match_end_n;
	logic           extending_n;
	logic [OB:0]    end_here;
	logic [OB:0]    mstart;
	logic           sx_ok;
	logic           tr_ok;
	logic           eof_hit;
	logic [1:0]     status_n;
	logic [63:0]    ext_wide;
	logic [31:0]    extent_n;

	assign end_here = (OB+1)'(offset_q) + (OB+1)'(1);
	assign mstart   = (OB+1)'(offset_q) - (OB+1)'(4);
	assign sx_ok = sx_valid_q && ((OB+1)'(sx_at_q) + (OB+1)'(window_q) >= mstart);
	assign tr_ok = tr_valid_q && ((OB+1)'(tr_at_q) + (OB+1)'(window_q) >= mstart);

	always_comb begin
		hist_n      = {hist_q[8*(pdx_pkg::HIST_BYTES-1)-1:0], data_s1};
		header_ok_n = header_ok_q;
		sx_valid_n  = sx_valid_q;
		sx_at_n     = sx_at_q;
		tr_valid_n  = tr_valid_q;
		tr_at_n     = tr_at_q;
		found_n     = found_q;
		match_end_n = match_end_q;
		extending_n = extending_q;
		eof_hit     = 1'b0;

		if (offset_q < OB'(pdx_pkg::HEAD_LEN)
			&& data_s1 != pdx_pkg::head_byte(offset_q[2:0])) begin
			header_ok_n = 1'b0;
		end

		if (extending_q) begin
			if (pdx_pkg::is_c_space(data_s1)) begin
				match_end_n = end_here;
			end else begin
				extending_n = 1'b0;
			end
		end

		if (offset_q >= OB'(8) && hist_n == pdx_pkg::STARTXREF_PAT) begin
			sx_valid_n = 1'b1;
			sx_at_n    = offset_q - OB'(8);
		end
		if (offset_q >= OB'(6) && hist_n[55:0] == pdx_pkg::TRAILER_PAT) begin
			tr_valid_n = 1'b1;
			tr_at_n    = offset_q - OB'(6);
		end
		if (offset_q >= OB'(9) && hist_n[39:0] == pdx_pkg::EOF_PAT) begin
			eof_hit = (window_q != 16'd0) && (sx_ok || tr_ok);
		end
		if (eof_hit) begin
			found_n     = 1'b1;
			match_end_n = end_here;
			extending_n = 1'b1;
		end

		offset_n = (offset_q == {OB{1'b1}}) ? offset_q : offset_q + OB'(1);

		status_n = pdx_pkg::STATUS_NONE;
		ext_wide = 64'd0;
		if (offset_n < OB'(pdx_pkg::HEAD_LEN)) begin
			status_n = (header_ok_n && !final_s1) ? pdx_pkg::STATUS_MORE
				: pdx_pkg::STATUS_NONE;
		end else if (!header_ok_n) begin
			status_n = pdx_pkg::STATUS_NONE;
		end else if (found_n) begin
			status_n = pdx_pkg::STATUS_MATCHED;
			ext_wide = 64'(match_end_n);
		end else if (final_s1) begin
			status_n = pdx_pkg::STATUS_PARTIAL;
			ext_wide = 64'(offset_n);
		end else begin
			status_n = pdx_pkg::STATUS_MORE;
		end
		extent_n = (ext_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : ext_wide[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= pdx_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q      <= '0;
			offset_q    <= '0;
			header_ok_q <= 1'b1;
			sx_valid_q  <= 1'b0;
			tr_valid_q  <= 1'b0;
			found_q     <= 1'b0;
			match_end_q <= '0;
			extending_q <= 1'b0;
		end else if (advance_s1) begin
			if (last_s1 && status_n != pdx_pkg::STATUS_MORE) begin
				hist_q      <= '0;
				offset_q    <= '0;
				header_ok_q <= 1'b1;
				sx_valid_q  <= 1'b0;
				tr_valid_q  <= 1'b0;
				found_q     <= 1'b0;
				match_end_q <= '0;
				extending_q <= 1'b0;
			end else begin
				hist_q      <= hist_n;
				offset_q    <= offset_n;
				header_ok_q <= header_ok_n;
				sx_valid_q  <= sx_valid_n;
				tr_valid_q  <= tr_valid_n;
				found_q     <= found_n;
				match_end_q <= match_end_n;
				extending_q <= extending_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			sx_at_q <= sx_at_n;
			tr_at_q <= tr_at_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			status_q <= status_n;
			extent_q <= extent_n;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.status        = status_q;
	assign result_ch.extent_length = extent_q;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] extent_length;
	} extent_t;

	localparam logic [39:0] HEADER_STR  = "%PDF-";
	localparam logic [39:0] MARKER_STR  = "%%EOF";
	localparam logic [71:0] XREF_STR    = "startxref";
	localparam logic [55:0] TRAILER_STR = "trailer";

	localparam int ROWS = 6;
	localparam int PHASE_BYTES = 170;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	pdx_byte_if   byte_ch();
	pdx_result_if result_ch();

	pdf_extent_detector uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	logic [15:0] window;
	logic [71:0] recent;
	logic [31:0] consumed;
	bit          header_good;
	bit          xref_valid;
	logic [31:0] xref_at;
	bit          trailer_valid;
	logic [31:0] trailer_at;
	bit          marker_valid;
	logic [32:0] claimed_end;
	bit          in_space;

	extent_t     expected_extents[$];
	logic [7:0]  cand_bytes[$];
	int          mismatches;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          long_hold_req;
	bit          long_hold_done;
	bit          row_typed;
	extent_t     row_extent;

	string   row_text[ROWS] = '{"%P", "DF-trailer%%EOF \n", "X", "%PDF-x", "\377", "%PD"};
	bit      row_fin[ROWS]  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
	bit      row_has[ROWS]  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
	extent_t row_want[ROWS] = '{
		'{pdx_pkg::STATUS_MORE, 32'd0},
		'{pdx_pkg::STATUS_NONE, 32'd0},
		'{pdx_pkg::STATUS_NONE, 32'd0},
		'{pdx_pkg::STATUS_PARTIAL, 32'd6},
		'{pdx_pkg::STATUS_NONE, 32'd0},
		'{pdx_pkg::STATUS_NONE, 32'd0}
	};

	function automatic void restart_candidate();
		recent        = '0;
		consumed      = '0;
		header_good   = 1'b1;
		xref_valid    = 1'b0;
		xref_at       = '0;
		trailer_valid = 1'b0;
		trailer_at    = '0;
		marker_valid  = 1'b0;
		claimed_end   = '0;
		in_space      = 1'b0;
	endfunction

	function automatic bit scan_byte(input logic [7:0] b, input bit last, input bit fin,
		output extent_t res);
		logic [31:0] o;
		logic [31:0] mstart;
		logic [31:0] lo;
		bit          hit;
		o = consumed;
		res = '0;
		recent = {recent[63:0], b};
		if (o < 5) begin
			if (b != HEADER_STR[39 - 8*o -: 8])
				header_good = 1'b0;
		end
		if (in_space) begin
			if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))
				claimed_end = {1'b0, o} + 33'd1;
			else
				in_space = 1'b0;
		end
		if (o >= 8 && recent == XREF_STR) begin
			xref_valid = 1'b1;
			xref_at = o - 8;
		end
		if (o >= 6 && recent[55:0] == TRAILER_STR) begin
			trailer_valid = 1'b1;
			trailer_at = o - 6;
		end
		if (o >= 9 && recent[39:0] == MARKER_STR) begin
			mstart = o - 4;
			lo = (mstart > {16'd0, window}) ? mstart - {16'd0, window} : 32'd0;
			hit = (window != 0) && ((xref_valid && xref_at >= lo) ||
				(trailer_valid && trailer_at >= lo));
			if (hit) begin
				marker_valid = 1'b1;
				claimed_end = {1'b0, mstart} + 33'd5;
				in_space = 1'b1;
			end
		end
		if (o != 32'hFFFF_FFFF)
			consumed = o + 1;
		if (!last)
			return 1'b0;
		if (consumed < 5) begin
			res.status = (header_good && !fin) ? pdx_pkg::STATUS_MORE : pdx_pkg::STATUS_NONE;
		end else if (!header_good) begin
			res.status = pdx_pkg::STATUS_NONE;
		end else if (marker_valid) begin
			res.status = pdx_pkg::STATUS_MATCHED;
			res.extent_length = claimed_end[32] ? 32'hFFFF_FFFF : claimed_end[31:0];
		end else if (fin) begin
			res.status = pdx_pkg::STATUS_PARTIAL;
			res.extent_length = consumed;
		end else begin
			res.status = pdx_pkg::STATUS_MORE;
		end
		if (res.status != pdx_pkg::STATUS_MORE)
			restart_candidate();
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		extent_t predicted;
		extent_t want;
		bit      produced;
		if (byte_ch.valid && byte_ch.ready) begin
			produced = scan_byte(byte_ch.data_byte, byte_ch.last_byte, byte_ch.final_chunk,
				predicted);
			if (produced)
				expected_extents = {expected_extents, (row_typed ? row_extent : predicted)};
		end
		if (result_ch.valid && result_ch.ready) begin
			if (expected_extents.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d length %0d",
						result_ch.status, result_ch.extent_length);
			end else begin
				want = expected_extents.pop_front();
				if (want.status !== result_ch.status ||
					want.extent_length !== result_ch.extent_length) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: status exp %0d got %0d, length exp %0d got %0d",
							want.status, result_ch.status, want.extent_length,
							result_ch.extent_length);
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAIL pdf_extent_detector");
		$finish;
	end

	initial begin
		result_ch.ready = 1'b0;
		long_hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n && long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (299) @(negedge clk);
			end else begin
				result_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit last, input bit fin);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.data_byte   <= b;
		byte_ch.last_byte   <= last;
		byte_ch.final_chunk <= fin;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// wait until every expected result has arrived or patience runs out, then let the pipeline empty
	task automatic drain(input int patience);
		int waited;
		waited = 0;
		byte_ch.valid <= 1'b0;
		row_typed <= 1'b0;
		while (expected_extents.size() != 0 && waited < patience) begin
			@(negedge clk);
			waited++;
		end
		if (expected_extents.size() != 0) begin
			mismatches += expected_extents.size();
			$display("missing %0d results", expected_extents.size());
			expected_extents.delete();
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic set_window(input logic [15:0] w);
		drain(20000);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		window = w;
		@(negedge clk);
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			cand_bytes = {cand_bytes, s[i]};
	endfunction

	function automatic void add_random(input int n);
		for (int i = 0; i < n; i++)
			cand_bytes = {cand_bytes, 8'($urandom_range(255))};
	endfunction

	function automatic void add_space(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(5);
			cand_bytes = {cand_bytes, (r == 5 ? 8'h20 : 8'h09 + 8'(r))};
		end
	endfunction

	task automatic send_candidate(output int count);
		int  pick;
		int  n;
		int  k;
		bit  last;
		bit  fin;
		cand_bytes.delete();
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++)
				send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
					1'($urandom_range(1)));
			count = n;
			return;
		end
		pick = $urandom_range(9);
		if (pick < 7) begin
			add_text("%PDF-");
		end else if (pick == 7) begin
			add_text("%PDF-");
			k = $urandom_range(4);
			cand_bytes[k] = 8'($urandom_range(255));
		end else begin
			add_random($urandom_range(1, 6));
		end
		n = $urandom_range(0, 7);
		for (int s = 0; s < n; s++) begin
			pick = $urandom_range(9);
			case (pick)
				0, 1: begin
					if ($urandom_range(7) == 0)
						add_random($urandom_range(10, 80));
					else
						add_random($urandom_range(0, 6));
				end
				2: add_text("startxref");
				3: add_text("trailer");
				4, 5: begin
					add_text("%%EOF");
					add_space($urandom_range(0, 3));
				end
				6: add_space($urandom_range(1, 3));
				7: begin
					k = $urandom_range(2);
					add_text(k == 0 ? "startxre" : (k == 1 ? "traile" : "%%EO"));
				end
				8: begin
					add_text("%%EOF");
					add_random(1);
				end
				default: add_text("\r\n0 ");
			endcase
		end
		foreach (cand_bytes[i]) begin
			if (i == cand_bytes.size() - 1) begin
				last = 1'b1;
				fin = $urandom_range(4) != 0;
			end else begin
				last = $urandom_range(24) == 0;
				fin = 1'($urandom_range(1));
			end
			send_byte(cand_bytes[i], last, fin);
		end
		count = cand_bytes.size();
	endtask

	initial begin
		int        sent;
		int        n;
		int        len;
		logic [15:0] phase_window[6];
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = '0;
		byte_ch.last_byte   = 1'b0;
		byte_ch.final_chunk = 1'b0;
		row_typed           = 1'b0;
		row_extent          = '0;
		long_hold_req       = 1'b0;
		mismatches          = 0;
		send_idle_pct       = 13;
		recv_idle_pct       = 45;
		window              = pdx_pkg::WINDOW_RESET;
		restart_candidate();
		phase_window = '{pdx_pkg::WINDOW_RESET, 16'd0, 16'd1, 16'hFFFF,
			16'($urandom_range(7, 40)), 16'($urandom_range(7, 100))};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < ROWS; r++) begin
			row_typed  <= row_has[r];
			row_extent <= row_want[r];
			len = row_text[r].len();
			for (int i = 0; i < len; i++)
				send_byte(row_text[r][i], i == len - 1, row_fin[r] && i == len - 1);
		end
		drain(20000);

		for (int p = 0; p < 6; p++) begin
			if (p >= 2) begin
				send_idle_pct = (p < 4) ? 45 : 0;
				recv_idle_pct = (p < 4) ? 13 : 0;
			end
			if (p != 0)
				set_window(phase_window[p]);
			if (p == 5)
				long_hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				send_candidate(n);
				sent += n;
			end
		end

		drain(50000);
		if (mismatches == 0)
			$display("PASS pdf_extent_detector");
		else
			$display("FAIL pdf_extent_detector");
		$finish;
	end

endmodule
